@@ design/mkh_pkg.sv @@
// Shared types and codes for the multi-key hash find-or-insert unit.
`default_nettype none
package mkh_pkg;

  localparam int unsigned CompFieldW = 16;
  localparam int unsigned SetIdW     = 9;
  localparam logic [31:0] HashMul    = 32'h9e3779b1;

  typedef enum logic [2:0] {
    ST_FOUND     = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_TOO_LONG  = 3'd4
  } status_e;

  typedef struct packed {
    logic                  mode;
    logic [CompFieldW-1:0] component;
    logic                  key_last;
  } in_item_t;

  typedef struct packed {
    logic [SetIdW-1:0] set_id;
    status_e           status;
  } out_item_t;

endpackage
`default_nettype wire

@@ design/multi_key_hash_find_or_insert_unit.sv @@
// Top level: open-addressed hash table keyed by lists of component ids.
//
// Channel   Direction  Handshake              Payload
// item in   in         start high, busy low   item_i (mode, component, key_last)
// result    out        res_valid_o strobe     res_o (set_id, status)
//
// A key element that is not last is only buffered. A last element starts the
// table walk: per probe, the key elements pass in turn through the shared hash
// multiplier, then slot reduction (a second pass when SLOTS is not a power of
// two), the slot read and check, and a read and a check per compared key
// element. An insert then copies the key in, one element at a time.
// After reset busy stays high while every slot id is cleared to empty.
// Results strobe for one cycle; the receiver cannot stall.
`default_nettype none
module multi_key_hash_find_or_insert_unit import mkh_pkg::*; #(
  parameter int unsigned SLOTS = 256,
  parameter int unsigned MAX_KEY = 16,
  parameter int unsigned COMP_WIDTH = 16
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  output logic           busy,
  input  wire in_item_t  item_i,
  output logic           res_valid_o,
  output out_item_t      res_o
);

  localparam int unsigned EW    = (COMP_WIDTH < CompFieldW) ? COMP_WIDTH : CompFieldW;
  localparam int unsigned SW    = $clog2(SLOTS);
  localparam int unsigned KAW   = $clog2(SLOTS * MAX_KEY);
  localparam int unsigned IDW   = $clog2(SLOTS + 2);
  localparam int unsigned LEN_W = $clog2(MAX_KEY + 2);
  localparam int unsigned KIW   = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1;
  localparam int unsigned PW    = $clog2(SLOTS + 1);
  localparam bit          Pow2  = ((SLOTS & (SLOTS - 1)) == 0);
  localparam logic [31:0] Recip = 32'((64'd1 << 32) / 64'(SLOTS));

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_HASH   = 9'b000000100,
    S_MOD    = 9'b000001000,
    S_READ   = 9'b000010000,
    S_CHECK  = 9'b000100000,
    S_CMP_RD = 9'b001000000,
    S_CMP_CK = 9'b010000000,
    S_COPY   = 9'b100000000
  } state_e;

  state_e           state_q, state_d;
  logic [EW-1:0]    kb_q [MAX_KEY];
  logic [LEN_W-1:0] kl_q, kl_d;
  logic             mode_q, mode_d;
  logic [PW-1:0]    probe_q, probe_d, maxp_q, maxp_d;
  logic [IDW-1:0]   nid_q, nid_d;
  logic [LEN_W-1:0] i_q, i_d;
  logic [SW-1:0]    s_q, s_d, clr_q, clr_d;
  logic [31:0]      quo_q, quo_d;
  logic             bc_q, bc_d;
  logic             res_valid_q, res_valid_d;
  out_item_t        res_q, res_d;

  logic             accept, kb_we, i_last;
  logic [LEN_W-1:0] kl_inc;
  logic [EW-1:0]    kb_cur;
  logic [63:0]      recip_prod;
  logic [31:0]      quo_prod;
  logic [SW:0]      mod_t, mod_r;
  logic             h_load, h_step;
  logic [31:0]      h_seed, hash;
  logic             id_we, len_we, key_we;
  logic [IDW-1:0]   id_wdata, id_rdata;
  logic [LEN_W-1:0] len_rdata;
  logic [EW-1:0]    key_rdata;
  logic [SW-1:0]    id_addr;
  logic [KAW-1:0]   key_addr;

  assign busy        = (state_q != S_IDLE);
  assign accept      = start && !busy;
  assign kb_we       = accept && (kl_q < LEN_W'(MAX_KEY));
  assign kl_inc      = (kl_q <= LEN_W'(MAX_KEY)) ? LEN_W'(kl_q + 1'b1) : kl_q;
  assign i_last      = (LEN_W'(i_q + 1'b1) == kl_q);
  assign kb_cur      = kb_q[i_q[KIW-1:0]];
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // Slot reduction when SLOTS is not a power of two: estimate the quotient
  // by reciprocal multiply (low by at most one), then one corrective subtract.
  assign recip_prod = 64'(hash) * 64'(Recip);
  assign quo_prod   = 32'(quo_q * 32'(SLOTS));
  assign mod_t      = (SW+1)'(hash - quo_prod);
  assign mod_r = (mod_t >= (SW+1)'(SLOTS)) ? (SW+1)'(mod_t - (SW+1)'(SLOTS)) : mod_t;

  assign id_addr  = (state_q == S_CLEAR) ? clr_q : s_q;
  assign key_addr = KAW'(KAW'(s_q) * KAW'(MAX_KEY) + KAW'(i_q));

  mkh_hash_unit #(.EW(EW)) u_hash (
    .clk_i  (clk_i),
    .load_i (h_load),
    .seed_i (h_seed),
    .step_i (h_step),
    .elem_i (kb_cur),
    .hash_o (hash)
  );

  mkh_slot_store #(
    .SLOTS(SLOTS), .MAX_KEY(MAX_KEY), .EW(EW), .IDW(IDW), .LEN_W(LEN_W)
  ) u_store (
    .clk_i       (clk_i),
    .id_addr_i   (id_addr),
    .id_we_i     (id_we),
    .id_wdata_i  (id_wdata),
    .len_we_i    (len_we),
    .len_wdata_i (kl_q),
    .id_rdata_o  (id_rdata),
    .len_rdata_o (len_rdata),
    .key_addr_i  (key_addr),
    .key_we_i    (key_we),
    .key_wdata_i (kb_cur),
    .key_rdata_o (key_rdata)
  );

  always_comb begin
    state_d     = state_q;
    kl_d        = kl_q;
    mode_d      = mode_q;
    probe_d     = probe_q;
    maxp_d      = maxp_q;
    nid_d       = nid_q;
    i_d         = i_q;
    s_d         = s_q;
    quo_d       = quo_q;
    bc_d        = bc_q;
    clr_d       = clr_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    h_load      = 1'b0;
    h_seed      = 32'(probe_q);
    h_step      = 1'b0;
    id_we       = 1'b0;
    id_wdata    = '0;
    len_we      = 1'b0;
    key_we      = 1'b0;

    case (state_q)
      S_CLEAR: begin
        // Sweep the slot ids to empty, one slot a cycle.
        id_we = 1'b1;
        clr_d = SW'(clr_q + 1'b1);
        if (clr_q == SW'(SLOTS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          kl_d   = kl_inc;
          mode_d = item_i.mode;
          if (item_i.key_last) begin
            if (kl_inc > LEN_W'(MAX_KEY)) begin
              // Key too long: answer at once, store nothing.
              res_valid_d  = 1'b1;
              res_d.set_id = '0;
              res_d.status = ST_TOO_LONG;
              kl_d         = '0;
            end else begin
              probe_d = '0;
              h_load  = 1'b1;
              h_seed  = '0;
              i_d     = '0;
              state_d = S_HASH;
            end
          end
        end
      end
      S_HASH: begin
        h_step = 1'b1;
        if (i_last) begin
          bc_d    = 1'b1;
          state_d = S_MOD;
        end else begin
          i_d = LEN_W'(i_q + 1'b1);
        end
      end
      S_MOD: begin
        if (Pow2) begin
          s_d     = hash[SW-1:0];
          state_d = S_READ;
        end else if (bc_q) begin
          quo_d = recip_prod[63:32];
          bc_d  = 1'b0;
        end else begin
          s_d     = mod_r[SW-1:0];
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_CHECK;
      end
      S_CHECK, S_CMP_CK: begin
        if (state_q == S_CHECK && id_rdata == '0) begin
          if (mode_q) begin
            // Empty slot: claim it and copy the key in.
            id_we    = 1'b1;
            id_wdata = nid_q;
            len_we   = 1'b1;
            if (probe_q > maxp_q) begin
              maxp_d = probe_q;
            end
            i_d     = '0;
            state_d = S_COPY;
          end else begin
            res_valid_d  = 1'b1;
            res_d.set_id = '0;
            res_d.status = ST_NOT_FOUND;
            kl_d         = '0;
            state_d      = S_IDLE;
          end
        end else if ((state_q == S_CHECK && len_rdata != kl_q) ||
                     (state_q == S_CMP_CK && key_rdata != kb_cur)) begin
          // Mismatch: give up or advance to the next probe.
          if (!mode_q && probe_q >= maxp_q) begin
            res_valid_d  = 1'b1;
            res_d.set_id = '0;
            res_d.status = ST_NOT_FOUND;
            kl_d         = '0;
            state_d      = S_IDLE;
          end else if (probe_q == PW'(SLOTS - 1)) begin
            res_valid_d  = 1'b1;
            res_d.set_id = '0;
            res_d.status = mode_q ? ST_FULL : ST_NOT_FOUND;
            kl_d         = '0;
            state_d      = S_IDLE;
          end else begin
            probe_d = PW'(probe_q + 1'b1);
            h_load  = 1'b1;
            h_seed  = 32'(PW'(probe_q + 1'b1));
            i_d     = '0;
            state_d = S_HASH;
          end
        end else if (state_q == S_CMP_CK && i_last) begin
          res_valid_d  = 1'b1;
          res_d.set_id = SetIdW'(id_rdata);
          res_d.status = ST_FOUND;
          kl_d         = '0;
          state_d      = S_IDLE;
        end else begin
          if (state_q == S_CMP_CK) begin
            i_d = LEN_W'(i_q + 1'b1);
          end else begin
            i_d = '0;
          end
          state_d = S_CMP_RD;
        end
      end
      S_CMP_RD: begin
        state_d = S_CMP_CK;
      end
      S_COPY: begin
        key_we = 1'b1;
        if (i_last) begin
          res_valid_d  = 1'b1;
          res_d.set_id = SetIdW'(nid_q);
          res_d.status = ST_INSERTED;
          nid_d        = IDW'(nid_q + 1'b1);
          kl_d         = '0;
          state_d      = S_IDLE;
        end else begin
          i_d = LEN_W'(i_q + 1'b1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      kl_q        <= '0;
      mode_q      <= 1'b0;
      probe_q     <= '0;
      maxp_q      <= '0;
      nid_q       <= IDW'(1);
      i_q         <= '0;
      bc_q        <= 1'b0;
      clr_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      kl_q        <= kl_d;
      mode_q      <= mode_d;
      probe_q     <= probe_d;
      maxp_q      <= maxp_d;
      nid_q       <= nid_d;
      i_q         <= i_d;
      bc_q        <= bc_d;
      clr_q       <= clr_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload registers hold without reset.
  always_ff @(posedge clk_i) begin
    s_q   <= s_d;
    quo_q <= quo_d;
    res_q <= res_d;
    if (kb_we) begin
      kb_q[kl_q[KIW-1:0]] <= EW'(item_i.component);
    end
  end

  a_fail_no_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (res_o.status == ST_NOT_FOUND || res_o.status == ST_FULL ||
                    res_o.status == ST_TOO_LONG) |-> res_o.set_id == '0)
    else $error("failed operation returned a nonzero set id");

  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(busy) || $past(start))
    else $error("result strobe without a preceding operation");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kl_q <= LEN_W'(MAX_KEY + 1))
    else $error("key length counter past saturation");

  a_max_probe_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    maxp_q < PW'(SLOTS))
    else $error("largest probe count out of range");

endmodule
`default_nettype wire

@@ design/mkh_hash_unit.sv @@
// Shared hash register with one xor-multiply step per cycle while step_i is high.
`default_nettype none
module mkh_hash_unit import mkh_pkg::*; #(
  parameter int unsigned EW = 16
) (
  input  wire logic          clk_i,
  input  wire logic          load_i,
  input  wire logic [31:0]   seed_i,
  input  wire logic          step_i,
  input  wire logic [EW-1:0] elem_i,
  output logic      [31:0]   hash_o
);

  logic [31:0] hash_q;
  logic [63:0] prod;

  assign prod   = 64'(hash_q ^ 32'(elem_i)) * 64'(HashMul);
  assign hash_o = hash_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      hash_q <= seed_i;
    end else if (step_i) begin
      hash_q <= prod[31:0];
    end
  end

endmodule
`default_nettype wire

@@ design/mkh_slot_store.sv @@
// Slot memories: id, key length and key elements of every slot.
`default_nettype none
module mkh_slot_store import mkh_pkg::*; #(
  parameter int unsigned SLOTS = 256,
  parameter int unsigned MAX_KEY = 16,
  parameter int unsigned EW = 16,
  parameter int unsigned IDW = 9,
  parameter int unsigned LEN_W = 5,
  localparam int unsigned SW = $clog2(SLOTS),
  localparam int unsigned KAW = $clog2(SLOTS * MAX_KEY)
) (
  input  wire logic             clk_i,
  input  wire logic [SW-1:0]    id_addr_i,
  input  wire logic             id_we_i,
  input  wire logic [IDW-1:0]   id_wdata_i,
  input  wire logic             len_we_i,
  input  wire logic [LEN_W-1:0] len_wdata_i,
  output logic      [IDW-1:0]   id_rdata_o,
  output logic      [LEN_W-1:0] len_rdata_o,
  input  wire logic [KAW-1:0]   key_addr_i,
  input  wire logic             key_we_i,
  input  wire logic [EW-1:0]    key_wdata_i,
  output logic      [EW-1:0]    key_rdata_o
);

  logic [IDW-1:0]   id_mem  [SLOTS];
  logic [LEN_W-1:0] len_mem [SLOTS];
  logic [EW-1:0]    key_mem [SLOTS*MAX_KEY];

  always_ff @(posedge clk_i) begin
    if (id_we_i) begin
      id_mem[id_addr_i] <= id_wdata_i;
    end
    id_rdata_o <= id_mem[id_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (len_we_i) begin
      len_mem[id_addr_i] <= len_wdata_i;
    end
    len_rdata_o <= len_mem[id_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (key_we_i) begin
      key_mem[key_addr_i] <= key_wdata_i;
    end
    key_rdata_o <= key_mem[key_addr_i];
  end

endmodule
`default_nettype wire

@@ verif/mkh_checker.sv @@
// Checker for the hash unit: predicts every result and compares it with the block's output.
`default_nettype none
module mkh_checker import mkh_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start_i,
  input  wire logic      busy_i,
  input  wire in_item_t  item_i,
  input  wire logic      res_valid_i,
  input  wire out_item_t res_i,
  output int             fail_count_o,
  output int             pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumSlots = 256;
  localparam int unsigned KeyMax   = 16;

  logic [15:0]       key_buf [KeyMax];
  int unsigned       key_len;
  logic [SetIdW-1:0] slot_set [NumSlots];
  int unsigned       slot_len [NumSlots];
  logic [15:0]       slot_key [NumSlots][KeyMax];
  logic [SetIdW-1:0] next_set;
  int unsigned       worst_probe;
  out_item_t         expected_q[$];

  function automatic logic [7:0] probe_slot(int unsigned seed);
    logic [31:0] h;
    h = seed;
    for (int i = 0; i < key_len; i++) h = (h ^ {16'b0, key_buf[i]}) * HashMul;
    return h[7:0];
  endfunction

  function automatic bit slot_holds_key(int unsigned s);
    if (slot_len[s] != key_len) return 0;
    for (int i = 0; i < key_len; i++) if (slot_key[s][i] != key_buf[i]) return 0;
    return 1;
  endfunction

  // Walk the table for the buffered key; update the table on insert.
  function automatic out_item_t find_or_insert(bit ins);
    out_item_t r;
    int unsigned s;
    r.set_id = '0;
    r.status = ins ? ST_FULL : ST_NOT_FOUND;
    if (key_len > KeyMax) begin
      r.status = ST_TOO_LONG;
      return r;
    end
    for (int unsigned p = 0; p < NumSlots; p++) begin
      s = probe_slot(p);
      if (slot_set[s] == '0) begin
        if (ins) begin
          if (p > worst_probe) worst_probe = p;
          slot_set[s] = next_set;
          slot_len[s] = key_len;
          for (int i = 0; i < key_len; i++) slot_key[s][i] = key_buf[i];
          r.set_id = next_set;
          r.status = ST_INSERTED;
          next_set = next_set + 1'b1;
        end else begin
          r.status = ST_NOT_FOUND;
        end
        return r;
      end
      if (slot_holds_key(s)) begin
        r.set_id = slot_set[s];
        r.status = ST_FOUND;
        return r;
      end
      if (!ins && p + 1 > worst_probe) begin
        r.status = ST_NOT_FOUND;
        return r;
      end
    end
    return r;
  endfunction

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_r;
    if (!rst_ni) begin
      key_len = 0;
      next_set = 1;
      worst_probe = 0;
      fail_count_o = 0;
      for (int s = 0; s < NumSlots; s++) slot_set[s] = '0;
      expected_q.delete();
    end else begin
      if (res_valid_i) begin
        if (expected_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("unexpected result: set_id %0d status %0d", res_i.set_id, res_i.status);
        end else begin
          exp_r = expected_q.pop_front();
          if (res_i.set_id !== exp_r.set_id || res_i.status !== exp_r.status) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("mismatch: expected set_id %0d status %0d, got set_id %0d status %0d",
                       exp_r.set_id, exp_r.status, res_i.set_id, res_i.status);
          end
        end
      end
      if (start_i && !busy_i) begin
        // Buffer the element; drop it once the key is too long.
        if (key_len < KeyMax) key_buf[key_len] = item_i.component;
        if (key_len <= KeyMax) key_len++;
        if (item_i.key_last) begin
          expected_q.push_back(find_or_insert(item_i.mode));
          key_len = 0;
        end
      end
    end
  end
endmodule
`default_nettype wire

@@ verif/tb_multi_key_hash_find_or_insert_unit.sv @@
// Testbench top: drives key items into the hash unit and reports the verdict.
`default_nettype none
module tb_multi_key_hash_find_or_insert_unit;
  import mkh_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PoolSize   = 300;
  localparam int CycleLimit = 20000000;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      start;
  logic      busy;
  in_item_t  item_i;
  logic      res_valid_o;
  out_item_t res_o;
  int        fail_count;
  int        pending;
  int        cycles = 0;
  int        idle_pct;

  // Key under construction and a pool of keys reused to hit found/insert paths.
  logic [15:0] key_elems [20];
  int          key_size;
  logic [15:0] pool_elems [PoolSize][16];
  int          pool_size [PoolSize];

  always #5 clk_i = ~clk_i;

  multi_key_hash_find_or_insert_unit DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .item_i(item_i), .res_valid_o(res_valid_o), .res_o(res_o)
  );

  mkh_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start), .busy_i(busy), .item_i(item_i),
    .res_valid_i(res_valid_o), .res_i(res_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Present one element, optionally after an idle gap; hold it until accepted.
  task automatic send_elem(logic mode, logic [15:0] comp, logic last);
    int gap;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= '{mode: mode, component: comp, key_last: last};
    do @(posedge clk_i); while (busy);
  endtask

  // Send key_elems[0 .. key_size-1]; mode matters only on the last element.
  task automatic send_key(logic mode);
    for (int i = 0; i < key_size; i++)
      send_elem(i == key_size - 1 ? mode : 1'($urandom), key_elems[i], i == key_size - 1);
  endtask

  task automatic one_elem_key(logic mode, logic [15:0] comp);
    key_size = 1;
    key_elems[0] = comp;
    send_key(mode);
  endtask

  task automatic fill_key(int n, logic [15:0] comp);
    key_size = n;
    for (int i = 0; i < n; i++) key_elems[i] = comp;
  endtask

  // Hold off the sender until every expected result is back.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin
    int pick;
    int items;
    start  = 1'b0;
    item_i = '0;
    rst_ni = 1'b0;
    idle_pct = 31;
    for (int k = 0; k < PoolSize; k++) begin
      pool_size[k] = ($urandom_range(99) < 90) ? $urandom_range(1, 3) : $urandom_range(4, 16);
      for (int i = 0; i < 16; i++) pool_elems[k][i] = 16'($urandom);
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, every status but full, full-length and overlong keys.
    one_elem_key(1'b1, 16'h0000);          // insert
    one_elem_key(1'b1, 16'hffff);          // insert
    one_elem_key(1'b0, 16'h0000);          // lookup, found
    one_elem_key(1'b0, 16'h1234);          // lookup, not found
    one_elem_key(1'b1, 16'h0000);          // find-or-insert on existing key
    fill_key(16, 16'hffff);
    send_key(1'b1);                        // longest allowed key
    send_key(1'b0);
    fill_key(17, 16'haaaa);
    send_key(1'b1);                        // one element too many
    fill_key(20, 16'h5555);
    send_key(1'b0);
    key_size = 2;
    key_elems[0] = 16'h0000;
    key_elems[1] = 16'hffff;
    send_key(1'b1);
    key_elems[0] = 16'hffff;
    key_elems[1] = 16'h0000;
    send_key(1'b0);                        // order matters: not found
    drain();

    // Random: three idling phases, mostly pool keys so the table fills up.
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 31 : (phase == 1) ? 47 : 0;
      items = 0;
      while (items < 560) begin
        pick = $urandom_range(99);
        if (pick < 85) begin
          int k;
          k = $urandom_range(PoolSize - 1);
          key_size = pool_size[k];
          for (int i = 0; i < key_size; i++) key_elems[i] = pool_elems[k][i];
        end else if (pick < 95) begin
          key_size = $urandom_range(1, 4);
          for (int i = 0; i < key_size; i++) key_elems[i] = 16'($urandom);
        end else begin
          key_size = $urandom_range(17, 20);
          for (int i = 0; i < key_size; i++) key_elems[i] = 16'($urandom);
        end
        send_key($urandom_range(99) < 60);
        items += key_size;
      end
      drain();
    end

    start <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
